### sv/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands, clocked on clk and disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define PPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/pps_pkg.sv
// ---------------------------------------------------------------------------
// pps_pkg
// Types and constants shared by the priority scheduler and its slot cells.
// ---------------------------------------------------------------------------
package pps_pkg;

  localparam int JOB_SLOTS_DEF = 16;
  localparam int TIME_W        = 16;

  typedef enum logic {
    CMD_ADD  = 1'b0,
    CMD_TICK = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_ACCEPT = 2'd0,
    ST_FULL   = 2'd1,
    ST_RAN    = 2'd2,
    ST_IDLE   = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [7:0]        job_ident;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
    logic [7:0]        urgency;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [7:0]        ran_ident;
    logic [TIME_W-1:0] wait_time;
    logic [TIME_W-1:0] burst_before;
    logic [TIME_W-1:0] burst_after;
    logic [TIME_W-1:0] turnaround;
  } rsp_t;

  // Best candidate and first free slot seen so far along the chain.
  typedef struct packed {
    logic              sel_found;
    logic [7:0]        urgency;
    logic [TIME_W-1:0] arrival;
    logic [7:0]        ident;
    logic [TIME_W-1:0] remaining;
    logic              free_found;
  } cand_t;

  // Update broadcast to the cells at the end of an item.
  typedef struct packed {
    logic load;
    logic dec;
  } cell_cmd_t;

endpackage

### sv/pps_cell.sv
// ---------------------------------------------------------------------------
// pps_cell
// One job slot. Compares its job with the candidate from the previous cell
// and registers the winner toward the next cell every cycle.
// ---------------------------------------------------------------------------
module pps_cell import pps_pkg::*; #(
  parameter int IDX_W      = 4,
  parameter int CELL_INDEX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  cand_t             cand_in,
  input  logic [IDX_W-1:0]  sel_idx_in,
  input  logic [IDX_W-1:0]  free_idx_in,
  output cand_t             cand_out,
  output logic [IDX_W-1:0]  sel_idx_out,
  output logic [IDX_W-1:0]  free_idx_out,
  input  logic [TIME_W-1:0] now_time,
  input  cell_cmd_t         cmd,
  input  logic [IDX_W-1:0]  cmd_idx,
  input  req_t              job,
  output logic              busy
);

  logic [7:0]        ident;
  logic [TIME_W-1:0] arrival;
  logic [TIME_W-1:0] remaining;
  logic [7:0]        urgency;

  logic hit;
  logic eligible;
  logic take_sel;
  logic take_free;

  assign hit      = (cmd_idx == IDX_W'(CELL_INDEX));
  assign eligible = busy && (arrival <= now_time);
  // Ties keep the incoming candidate, which comes from a lower slot.
  assign take_sel = eligible && (!cand_in.sel_found || (urgency < cand_in.urgency) ||
                    ((urgency == cand_in.urgency) && (arrival < cand_in.arrival)));
  assign take_free = !cand_in.free_found && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (hit && cmd.load) begin
      busy <= 1'b1;
    end else if (hit && cmd.dec && (remaining == TIME_W'(1))) begin
      busy <= 1'b0;
    end

    if (hit && cmd.load) begin
      ident     <= job.job_ident;
      arrival   <= job.arrival;
      remaining <= job.burst;
      urgency   <= job.urgency;
    end else if (hit && cmd.dec) begin
      remaining <= remaining - TIME_W'(1);
    end
  end

  // Hand the running winner to the next cell.
  always_ff @(posedge clk) begin
    cand_out.free_found <= cand_in.free_found || take_free;
    free_idx_out        <= take_free ? IDX_W'(CELL_INDEX) : free_idx_in;
    if (take_sel) begin
      cand_out.sel_found <= 1'b1;
      cand_out.urgency   <= urgency;
      cand_out.arrival   <= arrival;
      cand_out.ident     <= ident;
      cand_out.remaining <= remaining;
      sel_idx_out        <= IDX_W'(CELL_INDEX);
    end else begin
      cand_out.sel_found <= cand_in.sel_found;
      cand_out.urgency   <= cand_in.urgency;
      cand_out.arrival   <= cand_in.arrival;
      cand_out.ident     <= cand_in.ident;
      cand_out.remaining <= cand_in.remaining;
      sel_idx_out        <= sel_idx_in;
    end
  end

endmodule

### sv/preemptive_priority_scheduler.sv
// Preemptive priority scheduler. Jobs sit in a row of JOB_SLOTS slot cells;
// an add stores a job in the lowest free slot (or reports the table full),
// a tick runs the most urgent released job for one time unit and advances
// time, saturating at the field maximum. An add with a zero burst is accepted
// but not stored. The search candidate walks the cell chain one slot per cycle,
// then the done state commits the update and loads the result register. A
// stalled result register holds the commit until it drains; new items are
// taken only while no item is in flight.
// ---------------------------------------------------------------------------
// preemptive_priority_scheduler
// Top level: item sequencer, time counter, result register and slot chain.
// ---------------------------------------------------------------------------
module preemptive_priority_scheduler import pps_pkg::*; #(
  parameter int JOB_SLOTS = JOB_SLOTS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  `include "assert_macros.svh"

  localparam int IDX_W = (JOB_SLOTS > 1) ? $clog2(JOB_SLOTS) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t            state;
  logic [IDX_W-1:0]  cnt;
  req_t              item;
  logic [TIME_W-1:0] now_time;

  cand_t            cand     [0:JOB_SLOTS];
  logic [IDX_W-1:0] sel_idx  [0:JOB_SLOTS];
  logic [IDX_W-1:0] free_idx [0:JOB_SLOTS];
  logic [JOB_SLOTS-1:0] slot_busy;

  cell_cmd_t         cell_cmd;
  logic [IDX_W-1:0]  cmd_idx;
  logic              commit;
  logic [TIME_W-1:0] now_inc;
  rsp_t              rsp_next;
  cand_t             tail;

  assign cand[0]     = '0;
  assign sel_idx[0]  = '0;
  assign free_idx[0] = '0;

  for (genvar i = 0; i < JOB_SLOTS; i++) begin : g_cell
    pps_cell #(
      .IDX_W      (IDX_W),
      .CELL_INDEX (i)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .cand_in      (cand[i]),
      .sel_idx_in   (sel_idx[i]),
      .free_idx_in  (free_idx[i]),
      .cand_out     (cand[i+1]),
      .sel_idx_out  (sel_idx[i+1]),
      .free_idx_out (free_idx[i+1]),
      .now_time     (now_time),
      .cmd          (cell_cmd),
      .cmd_idx      (cmd_idx),
      .job          (item),
      .busy         (slot_busy[i])
    );
  end

  assign tail      = cand[JOB_SLOTS];
  assign req_stall = (state != S_IDLE);
  assign commit    = (state == S_DONE) && (!rsp_valid || !rsp_stall);
  assign now_inc   = (now_time == '1) ? now_time : now_time + TIME_W'(1);

  always_comb begin
    cell_cmd.load = commit && (item.cmd == CMD_ADD) && (item.burst != '0) &&
                    tail.free_found;
    cell_cmd.dec  = commit && (item.cmd == CMD_TICK) && tail.sel_found;
    cmd_idx       = cell_cmd.load ? free_idx[JOB_SLOTS] : sel_idx[JOB_SLOTS];
  end

  always_comb begin
    rsp_next = '0;
    case (item.cmd)
      CMD_ADD: begin
        rsp_next.status = ((item.burst == '0) || tail.free_found) ? ST_ACCEPT : ST_FULL;
      end
      CMD_TICK: begin
        if (tail.sel_found) begin
          rsp_next.status       = ST_RAN;
          rsp_next.ran_ident    = tail.ident;
          rsp_next.wait_time    = now_time - tail.arrival;
          rsp_next.burst_before = tail.remaining;
          rsp_next.burst_after  = tail.remaining - TIME_W'(1);
          rsp_next.turnaround   = now_inc - tail.arrival;
        end else begin
          rsp_next.status = ST_IDLE;
        end
      end
      default: rsp_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      now_time  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (commit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            item  <= req;
            cnt   <= '0;
            state <= S_SCAN;
          end
        end
        // Let the candidate walk the full chain with the table held still.
        S_SCAN: begin
          if (cnt == IDX_W'(JOB_SLOTS - 1)) begin
            state <= S_DONE;
          end else begin
            cnt <= cnt + IDX_W'(1);
          end
        end
        S_DONE: begin
          if (commit) begin
            rsp   <= rsp_next;
            state <= S_IDLE;
            if (item.cmd == CMD_TICK) begin
              now_time <= now_inc;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PPS_ASSERT_NEXT(a_time_monotonic, 1'b1, now_time >= $past(now_time), "time went backward")
  `PPS_ASSERT_NOW(a_scan_time_stable, state == S_SCAN, $stable(now_time), "time moved in scan")
  `PPS_ASSERT_NEXT(a_one_slot_per_item, 1'b1,
    $countones(slot_busy) <= $past($countones(slot_busy)) + 1, "more than one slot filled")
  `PPS_ASSERT_NOW(a_result_from_done, $rose(rsp_valid), $past(state) == S_DONE,
    "result raised outside commit")

endmodule

### tb/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the preemptive priority scheduler. A short directed
// table covers empty ticks, zero-burst adds, a full table and every
// tie-break. Random add/tick traffic with uneven gaps and output stalls
// follows, and a last random group mixes ticks with adds whose arrivals
// spread over the whole time range.
// Every result is checked field by field against the job table model, or
// against the fixed status and zero fields of a directed row.
// ---------------------------------------------------------------------------
module testbench;
  import pps_pkg::*;

  localparam int SLOTS       = JOB_SLOTS_DEF;
  localparam int ITEM_CYCLES = SLOTS + 2;
  localparam int RANDOM_JOBS = 820;
  localparam int CYCLE_LIMIT = 4_000_000;

  typedef struct {
    req_t    item;
    bit      typed;
    status_t status;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  // Model of the job table
  logic [15:0] clock_now;
  bit          job_live [SLOTS];
  logic [7:0]  job_ident [SLOTS];
  logic [15:0] job_arrival [SLOTS];
  logic [15:0] job_left [SLOTS];
  logic [7:0]  job_urgency [SLOTS];

  rsp_t      pending_rsp [$];
  plan_row_t plan [$];
  int        errors = 0;
  int        cycles = 0;
  int        status_seen [4];
  int        stall_left = 0;
  bit        quiet = 1'b0;

  preemptive_priority_scheduler dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_rsp.size());
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int pick_pause();
    int p;
    p = $urandom_range(99);
    if (quiet || p < 55) return 0;
    if (p < 85) return $urandom_range(3, 1);
    if (p < 97) return $urandom_range(12, 4);
    return $urandom_range(80, 20);
  endfunction

  // Apply one transfer to the job table and return the result it yields.
  function automatic rsp_t schedule_step(req_t r);
    rsp_t res;
    int   pick;
    res = '0;
    pick = -1;
    if (r.cmd == CMD_ADD) begin
      res.status = ST_ACCEPT;
      if (r.burst != 0) begin
        for (int k = 0; k < SLOTS; k++)
          if (!job_live[k] && pick < 0) pick = k;
        if (pick < 0) begin
          res.status = ST_FULL;
        end else begin
          job_live[pick]    = 1'b1;
          job_ident[pick]   = r.job_ident;
          job_arrival[pick] = r.arrival;
          job_left[pick]    = r.burst;
          job_urgency[pick] = r.urgency;
        end
      end
    end else begin
      // Strict compares keep the lower slot on a full tie.
      for (int k = 0; k < SLOTS; k++)
        if (job_live[k] && job_arrival[k] <= clock_now &&
            (pick < 0 || job_urgency[k] < job_urgency[pick] ||
             (job_urgency[k] == job_urgency[pick] &&
              job_arrival[k] < job_arrival[pick])))
          pick = k;
      if (pick >= 0) begin
        res.status       = ST_RAN;
        res.ran_ident    = job_ident[pick];
        res.wait_time    = clock_now - job_arrival[pick];
        res.burst_before = job_left[pick];
        res.burst_after  = job_left[pick] - 16'd1;
        job_left[pick]   = job_left[pick] - 16'd1;
        if (job_left[pick] == 0) job_live[pick] = 1'b0;
      end else begin
        res.status = ST_IDLE;
      end
      if (clock_now != 16'hFFFF) clock_now = clock_now + 16'd1;
      if (pick >= 0) res.turnaround = clock_now - job_arrival[pick];
    end
    return res;
  endfunction

  function automatic req_t make_item(int add_pct, bit wide_arrival);
    req_t r;
    int   sel;
    int   a;
    r.job_ident = 8'($urandom);
    r.arrival   = 16'($urandom);
    r.burst     = 16'($urandom);
    r.urgency   = 8'($urandom);
    if ($urandom_range(99) >= add_pct) begin
      r.cmd = CMD_TICK;
      return r;
    end
    r.cmd = CMD_ADD;
    sel = $urandom_range(99);
    if (wide_arrival && sel < 50) begin
      a = $urandom_range(65535);
    end else if (sel < 85) begin
      // Mostly just released or about to be.
      a = int'(clock_now) + int'($urandom_range(10)) - 6;
      if (a < 0) a = 0;
      if (a > 65535) a = 65535;
    end else begin
      a = $urandom_range(int'(clock_now));
    end
    r.arrival = 16'(a);
    if ($urandom_range(99) < 70) r.urgency = 8'($urandom_range(3));
    sel = $urandom_range(99);
    if (sel < 8) begin
      r.burst = 16'd0;
    end else if (sel < 80) begin
      r.burst = 16'($urandom_range(4, 1));
    end else if (sel < 99) begin
      r.burst = 16'($urandom_range(20, 5));
    end else begin
      // Keep long jobs at the back of the line so they do not hog the slices.
      r.burst   = 16'($urandom_range(65535, 1));
      r.urgency = 8'($urandom_range(255, 250));
    end
    return r;
  endfunction

  task automatic send_item(req_t r, bit typed, status_t st);
    int   pause;
    rsp_t want;
    pause = pick_pause();
    if (pause != 0) begin
      req_valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    want = schedule_step(r);
    if (typed) begin
      want = '0;
      want.status = st;
    end
    pending_rsp.push_back(want);
  endtask

  function automatic void plan_row(cmd_t c, logic [7:0] id, logic [15:0] arr,
                                   logic [15:0] bst, logic [7:0] urg, bit typed,
                                   status_t st);
    plan_row_t row;
    row.item.cmd       = c;
    row.item.job_ident = id;
    row.item.arrival   = arr;
    row.item.burst     = bst;
    row.item.urgency   = urg;
    row.typed          = typed;
    row.status         = st;
    plan.push_back(row);
  endfunction

  task automatic cmp_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      errors++;
    end
  endtask

  // Result side: check each transfer, then decide the stall for the next edge.
  always @(posedge clk) begin : rsp_side
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected result, expected none got %h", $time, rsp);
        errors++;
      end else begin
        want = pending_rsp.pop_front();
        cmp_field("status", 16'(want.status), 16'(rsp.status));
        cmp_field("ran_ident", 16'(want.ran_ident), 16'(rsp.ran_ident));
        cmp_field("wait_time", want.wait_time, rsp.wait_time);
        cmp_field("burst_before", want.burst_before, rsp.burst_before);
        cmp_field("burst_after", want.burst_after, rsp.burst_after);
        cmp_field("turnaround", want.turnaround, rsp.turnaround);
        status_seen[rsp.status]++;
      end
    end
    if (stall_left != 0) begin
      stall_left--;
      rsp_stall <= 1'b1;
    end else if (!quiet && $urandom_range(99) < 30) begin
      stall_left = pick_pause();
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  initial begin : stimulus
    req_t r;
    int   sent;
    int   group_len;
    int   add_pct;

    clock_now = '0;
    foreach (job_live[k]) job_live[k] = 1'b0;
    foreach (status_seen[k]) status_seen[k] = 0;

    // Empty table, zero burst, and the slot that waits for the end of time
    plan_row(CMD_TICK, 8'h00, 16'h0000, 16'h0000, 8'h00, 1'b1, ST_IDLE);
    plan_row(CMD_ADD, 8'h00, 16'h0000, 16'h0000, 8'h00, 1'b1, ST_ACCEPT);
    plan_row(CMD_ADD, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, ST_ACCEPT);
    // Tie on urgency and arrival, a later arrival, and a more urgent job
    plan_row(CMD_ADD, 8'h5A, 16'h0000, 16'h0001, 8'h07, 1'b1, ST_ACCEPT);
    plan_row(CMD_ADD, 8'hA5, 16'h0000, 16'h0001, 8'h07, 1'b1, ST_ACCEPT);
    plan_row(CMD_ADD, 8'h33, 16'h0001, 16'h0001, 8'h07, 1'b1, ST_ACCEPT);
    plan_row(CMD_ADD, 8'h44, 16'h0001, 16'h0002, 8'h00, 1'b1, ST_ACCEPT);
    for (int k = 0; k < SLOTS - 5; k++)
      plan_row(CMD_ADD, 8'(128 + k), 16'h0000, 16'h0001, 8'd200, 1'b1, ST_ACCEPT);
    plan_row(CMD_ADD, 8'h77, 16'h0000, 16'h0005, 8'h00, 1'b1, ST_FULL);
    for (int k = 0; k < 5; k++)
      plan_row(CMD_TICK, 8'h00, 16'h0000, 16'h0000, 8'h00, 1'b0, ST_IDLE);
    plan_row(CMD_TICK, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0, ST_IDLE);

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) send_item(plan[i].item, plan[i].typed, plan[i].status);

    // Random traffic in groups that lean toward adds, ticks, or neither
    sent = 0;
    while (sent < RANDOM_JOBS) begin
      group_len = $urandom_range(60, 20);
      case ($urandom_range(3))
        0: add_pct = 20;
        1: add_pct = 80;
        default: add_pct = 45;
      endcase
      quiet = ($urandom_range(7) == 0);
      for (int i = 0; i < group_len; i++) begin
        send_item(make_item(add_pct, 1'b0), 1'b0, ST_IDLE);
        sent++;
      end
    end

    // Urgent short job released at time zero, then arrivals over the whole range
    quiet = 1'b0;
    r = make_item(100, 1'b0);
    r.job_ident = 8'h11;
    r.arrival   = 16'h0000;
    r.burst     = 16'd2;
    r.urgency   = 8'h00;
    send_item(r, 1'b0, ST_IDLE);
    for (int i = 0; i < 60; i++) send_item(make_item(45, 1'b1), 1'b0, ST_IDLE);

    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (3 * ITEM_CYCLES) @(posedge clk);

    $display("covered %0d accepted adds, %0d full-table rejects, %0d slices, %0d idle ticks",
             status_seen[ST_ACCEPT], status_seen[ST_FULL], status_seen[ST_RAN],
             status_seen[ST_IDLE]);
    $display("scheduler time ended at %0d after %0d cycles, %0d mismatches",
             clock_now, cycles, errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/pps_pkg.sv
sv/pps_cell.sv
sv/preemptive_priority_scheduler.sv
tb/testbench.sv
